// File: rtl/sgpa_pkg.sv
// Shared types, constants and width helpers of the softened pairwise gravity block.
// No dependencies; every other file in rtl/ imports this package.
package sgpa_pkg;

    // Defaults of the top-level parameters
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration registers are always one 32-bit word
    localparam int CFG_BITS  = 32;
    localparam int GRAV_FRAC = 24;
    localparam logic [CFG_BITS-1:0] GRAV_RESET = 32'h0100_0000;
    localparam logic [CFG_BITS-1:0] SOFT_RESET = 32'h0001_0000;

    // Queue between front and back (power of two)
    localparam int FIFO_DEPTH = 4;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_GRAVITY   = 1'b0,
        REG_SOFTENING = 1'b1
    } reg_index_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Magnitude of a coordinate difference
    function automatic int mag_bits(input int w);
        return w + 1;
    endfunction

    // Integer square root of the squared distance
    function automatic int len_bits(input int w);
        return w + 2;
    endfunction

    // Softened distance r = len + softening
    function automatic int r_bits(input int w);
        return ((len_bits(w) > CFG_BITS) ? len_bits(w) : CFG_BITS) + 1;
    endfunction

endpackage

// File: rtl/sgpa_front.sv
// Front end: accepts a body pair, forms the difference vector and the softened distance.
// Depends on sgpa_pkg. Distance uses a bit-per-stage pipelined integer square root.
module sgpa_front #(
    parameter int WORD_BITS = sgpa_pkg::WORD_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        pair_valid,
    output logic                                        pair_stall,
    input  logic signed [WORD_BITS-1:0]                 a_pos_x,
    input  logic signed [WORD_BITS-1:0]                 a_pos_y,
    input  logic signed [WORD_BITS-1:0]                 b_pos_x,
    input  logic signed [WORD_BITS-1:0]                 b_pos_y,
    input  logic        [WORD_BITS-1:0]                 b_mass,
    input  logic        [sgpa_pkg::CFG_BITS-1:0]        softening,
    input  sgpa_pkg::fifo_status_t                      q_status,
    output logic                                        push,
    output logic                                        f_nx,
    output logic                                        f_ny,
    output logic [sgpa_pkg::mag_bits(WORD_BITS)-1:0]    f_mx,
    output logic [sgpa_pkg::mag_bits(WORD_BITS)-1:0]    f_my,
    output logic [WORD_BITS-1:0]                        f_mass,
    output logic [sgpa_pkg::r_bits(WORD_BITS)-1:0]      f_r,
    output logic                                        f_rzero
);
    import sgpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int MW = mag_bits(W);
    localparam int LW = len_bits(W);
    localparam int RW = r_bits(W);
    localparam int TW = 2 * LW + 1;

    logic en_f;

    // Stage 0: difference vector
    logic           v0_reg;
    logic [W:0]     dx_reg, dy_reg;
    logic [W-1:0]   m0_reg;
    // Stage 1: sign and magnitude
    logic           v1_reg, nx1_reg, ny1_reg;
    logic [MW-1:0]  mx1_reg, my1_reg;
    logic [W-1:0]   m1_reg;
    // Stage 2: squares
    logic           v2_reg, nx2_reg, ny2_reg;
    logic [MW-1:0]  mx2_reg, my2_reg;
    logic [2*MW-1:0] sqx_reg, sqy_reg;
    logic [W-1:0]   m2_reg;
    // Square root stages
    logic           sv_reg  [0:LW];
    logic           snx_reg [0:LW];
    logic           sny_reg [0:LW];
    logic [MW-1:0]  smx_reg [0:LW];
    logic [MW-1:0]  smy_reg [0:LW];
    logic [W-1:0]   sm_reg  [0:LW];
    logic [TW-1:0]  rem_reg [0:LW];
    logic [LW-1:0]  res_reg [0:LW];
    // Output stage
    logic           vout_reg;
    logic [RW-1:0]  r_next;

    // Pipeline moves unless the finished item cannot enter the queue
    assign en_f       = !(vout_reg && q_status.full);
    assign pair_stall = !en_f;
    assign push       = vout_reg && !q_status.full;

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sv_reg[0] <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en_f)
        begin
            v0_reg    <= pair_valid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
            vout_reg  <= sv_reg[LW];
        end
    end

    // Fixed stages ahead of the square root
    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            dx_reg  <= {b_pos_x[W-1], b_pos_x} - {a_pos_x[W-1], a_pos_x};
            dy_reg  <= {b_pos_y[W-1], b_pos_y} - {a_pos_y[W-1], a_pos_y};
            m0_reg  <= b_mass;
            nx1_reg <= dx_reg[W];
            ny1_reg <= dy_reg[W];
            mx1_reg <= dx_reg[W] ? (~dx_reg + 1'b1) : dx_reg;
            my1_reg <= dy_reg[W] ? (~dy_reg + 1'b1) : dy_reg;
            m1_reg  <= m0_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            mx2_reg <= mx1_reg;
            my2_reg <= my1_reg;
            sqx_reg <= mx1_reg * mx1_reg;
            sqy_reg <= my1_reg * my1_reg;
            m2_reg  <= m1_reg;
            snx_reg[0] <= nx2_reg;
            sny_reg[0] <= ny2_reg;
            smx_reg[0] <= mx2_reg;
            smy_reg[0] <= my2_reg;
            sm_reg[0]  <= m2_reg;
            rem_reg[0] <= TW'(sqx_reg) + TW'(sqy_reg);
            res_reg[0] <= '0;
        end
    end

    // Square root: one result bit per stage, most significant first
    for (genvar j = 0; j < LW; j++)
    begin : g_sqrt
        localparam int B = LW - 1 - j;
        logic [TW-1:0] trial;
        logic          take;

        assign trial = (TW'(res_reg[j]) << (B + 1)) + (TW'(1) << (2 * B));
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[j+1] <= 1'b0;
            else if (en_f)
                sv_reg[j+1] <= sv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en_f)
            begin
                snx_reg[j+1] <= snx_reg[j];
                sny_reg[j+1] <= sny_reg[j];
                smx_reg[j+1] <= smx_reg[j];
                smy_reg[j+1] <= smy_reg[j];
                sm_reg[j+1]  <= sm_reg[j];
                rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                res_reg[j+1] <= take ? (res_reg[j] | (LW'(1) << B)) : res_reg[j];
            end
        end
    end

    // Softened distance
    assign r_next = RW'(res_reg[LW]) + RW'(softening);

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            f_nx    <= snx_reg[LW];
            f_ny    <= sny_reg[LW];
            f_mx    <= smx_reg[LW];
            f_my    <= smy_reg[LW];
            f_mass  <= sm_reg[LW];
            f_r     <= r_next;
            f_rzero <= (r_next == '0);
        end
    end

endmodule

// File: rtl/sgpa_fifo.sv
// Short flop-based queue between the front end and the back end.
// Depends on sgpa_pkg for the status struct and default depth.
module sgpa_fifo #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = sgpa_pkg::FIFO_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [DATA_BITS-1:0]   wdata,
    input  logic                   pop,
    output logic [DATA_BITS-1:0]   rdata,
    output sgpa_pkg::fifo_status_t status
);
    import sgpa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]        wptr_reg, rptr_reg;
    logic [CW-1:0]        count_reg, count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = mem_reg[rptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers wrap naturally since the depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

// File: rtl/sgpa_back.sv
// Back end: builds numerator and r^3, divides bit per stage, saturates and signs.
// Depends on sgpa_pkg for widths and format constants.
module sgpa_back #(
    parameter int WORD_BITS = sgpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = sgpa_pkg::FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  sgpa_pkg::fifo_status_t                      q_status,
    output logic                                        pop,
    input  logic                                        q_nx,
    input  logic                                        q_ny,
    input  logic [sgpa_pkg::mag_bits(WORD_BITS)-1:0]    q_mx,
    input  logic [sgpa_pkg::mag_bits(WORD_BITS)-1:0]    q_my,
    input  logic [WORD_BITS-1:0]                        q_mass,
    input  logic [sgpa_pkg::r_bits(WORD_BITS)-1:0]      q_r,
    input  logic                                        q_rzero,
    input  logic [sgpa_pkg::CFG_BITS-1:0]               gravity_const,
    output logic                                        accel_valid,
    input  logic                                        accel_stall,
    output logic signed [WORD_BITS-1:0]                 accel_x,
    output logic signed [WORD_BITS-1:0]                 accel_y,
    output logic                                        saturated
);
    import sgpa_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int MW    = mag_bits(W);
    localparam int RW    = r_bits(W);
    localparam int PW    = MW + CFG_BITS;
    localparam int SPL   = PW / 2;
    localparam int PHW   = PW - SPL;
    localparam int NUMW  = PW + W;
    localparam int DENW  = 3 * RW;
    localparam int E     = 2 * FRAC_BITS - GRAV_FRAC;
    localparam int ESH_N = (E > 0) ? E : 0;
    localparam int ESH_D = (E < 0) ? -E : 0;
    localparam int NSW   = NUMW + ESH_N;
    localparam int DSW   = DENW + ESH_D;
    localparam int CW    = ((NSW > DSW + W) ? NSW : DSW + W) + 1;

    logic en_b;

    // Stage 1: first products
    logic            v1_reg, nx1_reg, ny1_reg, rz1_reg;
    logic [PW-1:0]   pgx_reg, pgy_reg;
    logic [2*RW-1:0] r2_reg;
    logic [RW-1:0]   r1_reg;
    logic [W-1:0]    m1_reg;
    // Stage 2: partial products
    logic            v2_reg, nx2_reg, ny2_reg, rz2_reg;
    logic [SPL+W-1:0] pxl_reg, pyl_reg;
    logic [PHW+W-1:0] pxh_reg, pyh_reg;
    logic [2*RW-1:0] dl_reg, dh_reg;
    // Divider stages
    logic            dv_reg  [0:W];
    logic            dnx_reg [0:W];
    logic            dny_reg [0:W];
    logic            drz_reg [0:W];
    logic            ovx_reg [0:W];
    logic            ovy_reg [0:W];
    logic [DSW-1:0]  den_reg [0:W];
    logic [CW-1:0]   rx_reg  [0:W];
    logic [CW-1:0]   ry_reg  [0:W];
    logic [W-1:0]    qx_reg  [0:W];
    logic [W-1:0]    qy_reg  [0:W];
    // Numerator and denominator assembly
    logic [NSW-1:0]  numx, numy;
    logic [DSW-1:0]  den;
    // Output stage
    logic            vout_reg;
    logic [W-1:0]    ax_next, ay_next;
    logic            satx, saty;

    // Back end moves unless the result register is held
    assign en_b        = !(vout_reg && accel_stall);
    assign pop         = en_b && !q_status.empty;
    assign accel_valid = vout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            vout_reg  <= 1'b0;
        end
        else if (en_b)
        begin
            v1_reg    <= !q_status.empty;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            vout_reg  <= dv_reg[W];
        end
    end

    // Products, then split products, then assembled numerator and r^3
    assign numx = NSW'((NUMW'(pxh_reg) << SPL) + NUMW'(pxl_reg)) << ESH_N;
    assign numy = NSW'((NUMW'(pyh_reg) << SPL) + NUMW'(pyl_reg)) << ESH_N;
    assign den  = DSW'((DENW'(dh_reg) << RW) + DENW'(dl_reg)) << ESH_D;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            nx1_reg <= q_nx;
            ny1_reg <= q_ny;
            rz1_reg <= q_rzero;
            pgx_reg <= q_mx * gravity_const;
            pgy_reg <= q_my * gravity_const;
            r2_reg  <= q_r * q_r;
            r1_reg  <= q_r;
            m1_reg  <= q_mass;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            rz2_reg <= rz1_reg;
            pxl_reg <= pgx_reg[SPL-1:0] * m1_reg;
            pxh_reg <= pgx_reg[PW-1:SPL] * m1_reg;
            pyl_reg <= pgy_reg[SPL-1:0] * m1_reg;
            pyh_reg <= pgy_reg[PW-1:SPL] * m1_reg;
            dl_reg  <= r2_reg[RW-1:0] * r1_reg;
            dh_reg  <= r2_reg[2*RW-1:RW] * r1_reg;
            // quotient of 2^W or more always saturates
            dnx_reg[0] <= nx2_reg;
            dny_reg[0] <= ny2_reg;
            drz_reg[0] <= rz2_reg;
            den_reg[0] <= den;
            rx_reg[0]  <= CW'(numx);
            ry_reg[0]  <= CW'(numy);
            ovx_reg[0] <= CW'(numx) >= (CW'(den) << W);
            ovy_reg[0] <= CW'(numy) >= (CW'(den) << W);
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < W; j++)
    begin : g_div
        localparam int B = W - 1 - j;
        logic [CW-1:0] trial;
        logic          gex, gey;

        assign trial = CW'(den_reg[j]) << B;
        assign gex   = rx_reg[j] >= trial;
        assign gey   = ry_reg[j] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= 1'b0;
            else if (en_b)
                dv_reg[j+1] <= dv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                dnx_reg[j+1] <= dnx_reg[j];
                dny_reg[j+1] <= dny_reg[j];
                drz_reg[j+1] <= drz_reg[j];
                ovx_reg[j+1] <= ovx_reg[j];
                ovy_reg[j+1] <= ovy_reg[j];
                den_reg[j+1] <= den_reg[j];
                rx_reg[j+1]  <= gex ? (rx_reg[j] - trial) : rx_reg[j];
                ry_reg[j+1]  <= gey ? (ry_reg[j] - trial) : ry_reg[j];
                qx_reg[j+1]  <= {qx_reg[j][W-2:0], gex};
                qy_reg[j+1]  <= {qy_reg[j][W-2:0], gey};
            end
        end
    end

    // Clamp the magnitude and apply the sign
    function automatic logic [W:0] clamp_sign(input logic neg, input logic ovf,
                                              input logic [W-1:0] q);
        logic [W-1:0] limit;
        logic         sat;
        logic [W-1:0] mag;
        limit = neg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - 1'b1);
        sat   = ovf || (q > limit);
        mag   = sat ? limit : q;
        return {sat, neg ? (~mag + 1'b1) : mag};
    endfunction

    always_comb
    begin
        {satx, ax_next} = clamp_sign(dnx_reg[W], ovx_reg[W], qx_reg[W]);
        {saty, ay_next} = clamp_sign(dny_reg[W], ovy_reg[W], qy_reg[W]);
    end

    // Result register; zero distance gives zero with the flag set
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            accel_x   <= drz_reg[W] ? '0 : ax_next;
            accel_y   <= drz_reg[W] ? '0 : ay_next;
            saturated <= drz_reg[W] || satx || saty;
        end
    end

endmodule

// File: rtl/softened_pairwise_gravity_accel_top.sv
// Pipelines: a bit-per-stage square root (WORD_BITS+2 stages) in the front end, then the queue,
// then the divider (WORD_BITS stages) in the back end, lie between an accepted pair and its result.
// Throughput: one pair per cycle; both pipelines hold in place while stalled.
// Reset: asynchronous, active low; clears valid state and loads G = 1.0, softening = 1.0.
// No memory clearing pass is needed after reset.
// Holds the configuration registers and joins front end, queue and back end.
module softened_pairwise_gravity_accel_top #(
    parameter int WORD_BITS = sgpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = sgpa_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [sgpa_pkg::CFG_BITS-1:0] pwdata,
    output logic [sgpa_pkg::CFG_BITS-1:0] prdata,
    output logic                          pready,
    // pair channel
    input  logic                          pair_valid,
    output logic                          pair_stall,
    input  logic signed [WORD_BITS-1:0]   a_pos_x,
    input  logic signed [WORD_BITS-1:0]   a_pos_y,
    input  logic signed [WORD_BITS-1:0]   b_pos_x,
    input  logic signed [WORD_BITS-1:0]   b_pos_y,
    input  logic        [WORD_BITS-1:0]   b_mass,
    // acceleration channel
    output logic                          accel_valid,
    input  logic                          accel_stall,
    output logic signed [WORD_BITS-1:0]   accel_x,
    output logic signed [WORD_BITS-1:0]   accel_y,
    output logic                          saturated
);
    import sgpa_pkg::*;

    localparam int MW = mag_bits(WORD_BITS);
    localparam int RW = r_bits(WORD_BITS);
    localparam int QW = 3 + 2 * MW + WORD_BITS + RW;

    logic [CFG_BITS-1:0] grav_reg, soft_reg;
    reg_index_t          reg_idx;
    fifo_status_t        q_status;
    logic                push, pop;
    logic                f_nx, f_ny, f_rzero, q_nx, q_ny, q_rzero;
    logic [MW-1:0]       f_mx, f_my, q_mx, q_my;
    logic [WORD_BITS-1:0] f_mass, q_mass;
    logic [RW-1:0]       f_r, q_r;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= GRAV_RESET;
            soft_reg <= SOFT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_GRAVITY:   grav_reg <= pwdata;
                REG_SOFTENING: soft_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRAVITY:   prdata = grav_reg;
            REG_SOFTENING: prdata = soft_reg;
            default:       prdata = '0;
        endcase
    end

    sgpa_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .a_pos_x    (a_pos_x),
        .a_pos_y    (a_pos_y),
        .b_pos_x    (b_pos_x),
        .b_pos_y    (b_pos_y),
        .b_mass     (b_mass),
        .softening  (soft_reg),
        .q_status   (q_status),
        .push       (push),
        .f_nx       (f_nx),
        .f_ny       (f_ny),
        .f_mx       (f_mx),
        .f_my       (f_my),
        .f_mass     (f_mass),
        .f_r        (f_r),
        .f_rzero    (f_rzero)
    );

    sgpa_fifo #(
        .DATA_BITS (QW),
        .DEPTH     (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({f_rzero, f_nx, f_ny, f_mx, f_my, f_mass, f_r}),
        .pop    (pop),
        .rdata  ({q_rzero, q_nx, q_ny, q_mx, q_my, q_mass, q_r}),
        .status (q_status)
    );

    sgpa_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop           (pop),
        .q_nx          (q_nx),
        .q_ny          (q_ny),
        .q_mx          (q_mx),
        .q_my          (q_my),
        .q_mass        (q_mass),
        .q_r           (q_r),
        .q_rzero       (q_rzero),
        .gravity_const (grav_reg),
        .accel_valid   (accel_valid),
        .accel_stall   (accel_stall),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .saturated     (saturated)
    );

endmodule
